@@ src/hsv_to_rgb_converter_assert.svh @@
// assertion helpers for the hsv to rgb converter
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// checked while out of reset
`define HSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define HSV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/hsv_pkg.sv @@
package hsv_pkg;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  // hue arithmetic on an offset 17-bit copy of the hue
  localparam logic [16:0] HUE_OFFSET  = 17'd34560;
  localparam logic [16:0] HUE_SECTOR  = 17'd960;
  localparam logic [10:0] SEC_RECIP   = 11'd1092;
  localparam int          SEC_SHIFT   = 20;
  localparam logic [5:0]  SIX_RECIP   = 6'd43;
  localparam int          SIX_SHIFT   = 8;
  localparam logic [20:0] R15_RECIP   = 21'd1118481;
  localparam int          R15_SHIFT   = 24;
  localparam int          COLOR_W     = 9;
  localparam int          CLAMP_W     = 10;

endpackage

@@ src/hsv_to_rgb_converter.sv @@
// hsv to rgb pixel converter
// input channel s_axis: one hsv pixel per beat, hue in 1/16 degree (any value,
// wrapped modulo 360 degrees), saturation and brightness signed with
// COLOR_FRAC_BITS fraction bits, clamped to 0..1
// output channel m_axis: one rgb pixel per beat, 9-bit channels with
// COLOR_FRAC_BITS fraction bits
// throughput: one pixel per cycle while the receiver does not stall; the seven
// register stages are set by the reciprocal multiplies for the sector split and
// the fraction, then the saturation and brightness multiplies
// reset clears all stage valid bits, so no output beat is pending after it
// when the receiver stalls the whole pipeline holds in place, s_axis_tready
// drops, and every beat resumes unchanged once m_axis_tready returns
// zero saturation yields gray with all three channels equal to brightness
module hsv_to_rgb_converter #(
  parameter int COLOR_FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // hue[15:0], saturation[26:16], brightness[37:27]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // red[8:0], green[17:9], blue[26:18]
);

  import hsv_pkg::*;

  localparam int F      = COLOR_FRAC_BITS;
  localparam int ONE_W  = F + 1;
  localparam int YW     = F + 4;
  localparam int PW     = CLAMP_W + ONE_W;
  localparam int NS     = 7;
  localparam logic [ONE_W-1:0] ONE = {1'b1, {F{1'b0}}};
  localparam int ONE_INT = 1 << F;
  localparam logic [CLAMP_W-1:0] CLAMP_MAX =
    CLAMP_W'((ONE_INT < 1023) ? ONE_INT : 1023);

  function automatic logic [CLAMP_W-1:0] clamp_unit(input logic [10:0] x);
    logic [CLAMP_W-1:0] r;
    if (x[10]) begin
      r = '0;
    end else if (x[9:0] > CLAMP_MAX) begin
      r = CLAMP_MAX;
    end else begin
      r = x[9:0];
    end
    return r;
  endfunction

  logic          en;
  logic [NS-1:0] vld_q;

  assign en            = !vld_q[NS-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], s_axis_tvalid};
    end
  end

  // stage 1: clamp, offset hue, sector estimate
  logic [16:0]        u1_d, u1_q;
  logic [27:0]        est_prod;
  logic [6:0]         est1_q;
  logic [CLAMP_W-1:0] s1_d, v1_d, s1_q, v1_q;
  logic               zero1_q;

  assign u1_d     = {s_axis_tdata[15], s_axis_tdata[15:0]} + HUE_OFFSET;
  assign est_prod = 28'(u1_d) * 28'(SEC_RECIP);
  assign s1_d     = clamp_unit(s_axis_tdata[26:16]);
  assign v1_d     = clamp_unit(s_axis_tdata[37:27]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      u1_q    <= u1_d;
      est1_q  <= est_prod[SEC_SHIFT+6:SEC_SHIFT];
      s1_q    <= s1_d;
      v1_q    <= v1_d;
      zero1_q <= (s1_d == '0);
    end
  end

  // stage 2: remainder, sector, scaled remainder
  logic [16:0]        rem0, rem_fix;
  logic [6:0]         qq;
  logic [11:0]        six_prod;
  logic [6:0]         sec_raw;
  logic [CLAMP_W+F-1:0] rem_ext;
  sector_e            sec2_q;
  logic [YW-1:0]      y2_q;
  logic [CLAMP_W-1:0] s2_q, v2_q;
  logic               zero2_q;

  assign rem0     = u1_q - 17'(est1_q) * HUE_SECTOR;
  assign rem_fix  = (rem0 >= HUE_SECTOR) ? rem0 - HUE_SECTOR : rem0;
  assign qq       = (rem0 >= HUE_SECTOR) ? est1_q + 7'd1 : est1_q;
  assign six_prod = 12'(qq) * 12'(SIX_RECIP);
  assign sec_raw  = qq - 7'(six_prod >> SIX_SHIFT) * 7'd6;
  assign rem_ext  = {rem_fix[CLAMP_W-1:0], {F{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en) begin
      sec2_q  <= sector_e'(sec_raw[2:0]);
      y2_q    <= rem_ext[YW+5:6];
      s2_q    <= s1_q;
      v2_q    <= v1_q;
      zero2_q <= zero1_q;
    end
  end

  // stage 3: fraction estimate by reciprocal of 15, p product
  logic [YW+20:0]     f_prod;
  logic [PW-1:0]      p_prod;
  logic [F-1:0]       fest3_q;
  logic [YW-1:0]      y3_q;
  logic [CLAMP_W-1:0] p3_q, s3_q, v3_q;
  sector_e            sec3_q;
  logic               zero3_q;

  assign f_prod = (YW+21)'(y2_q) * (YW+21)'(R15_RECIP);
  assign p_prod = PW'(v2_q) * PW'(ONE - ONE_W'(s2_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      fest3_q <= f_prod[R15_SHIFT+F-1:R15_SHIFT];
      y3_q    <= y2_q;
      p3_q    <= p_prod[F+CLAMP_W-1:F];
      s3_q    <= s2_q;
      v3_q    <= v2_q;
      sec3_q  <= sec2_q;
      zero3_q <= zero2_q;
    end
  end

  // stage 4: fraction correction
  logic [YW-1:0]      f_left;
  logic [F-1:0]       f4_q;
  logic [CLAMP_W-1:0] p4_q, s4_q, v4_q;
  sector_e            sec4_q;
  logic               zero4_q;

  assign f_left = y3_q - YW'(fest3_q) * YW'(15);

  always_ff @(posedge clk_i) begin
    if (en) begin
      f4_q    <= (f_left >= YW'(15)) ? fest3_q + F'(1) : fest3_q;
      p4_q    <= p3_q;
      s4_q    <= s3_q;
      v4_q    <= v3_q;
      sec4_q  <= sec3_q;
      zero4_q <= zero3_q;
    end
  end

  // stage 5: saturation times fraction
  logic [PW-1:0]      sf5_q, sg5_q;
  logic [CLAMP_W-1:0] p5_q, v5_q;
  sector_e            sec5_q;
  logic               zero5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sf5_q   <= PW'(s4_q) * PW'(f4_q);
      sg5_q   <= PW'(s4_q) * PW'(ONE - ONE_W'(f4_q));
      p5_q    <= p4_q;
      v5_q    <= v4_q;
      sec5_q  <= sec4_q;
      zero5_q <= zero4_q;
    end
  end

  // stage 6: q and t
  logic [ONE_W-1:0]   qm, tm;
  logic [PW-1:0]      q_prod, t_prod;
  logic [CLAMP_W-1:0] q6_q, t6_q, p6_q, v6_q;
  sector_e            sec6_q;
  logic               zero6_q;

  assign qm     = ONE - ONE_W'(sf5_q >> F);
  assign tm     = ONE - ONE_W'(sg5_q >> F);
  assign q_prod = PW'(v5_q) * PW'(qm);
  assign t_prod = PW'(v5_q) * PW'(tm);

  always_ff @(posedge clk_i) begin
    if (en) begin
      q6_q    <= q_prod[F+CLAMP_W-1:F];
      t6_q    <= t_prod[F+CLAMP_W-1:F];
      p6_q    <= p5_q;
      v6_q    <= v5_q;
      sec6_q  <= sec5_q;
      zero6_q <= zero5_q;
    end
  end

  // stage 7: channel order and output register
  logic [CLAMP_W-1:0] r_d, g_d, b_d;
  logic [COLOR_W-1:0] red_q, green_q, blue_q;

  always_comb begin
    if (zero6_q) begin
      r_d = v6_q;
      g_d = v6_q;
      b_d = v6_q;
    end else begin
      case (sec6_q)
        SEC_RED_YEL: begin r_d = v6_q; g_d = t6_q; b_d = p6_q; end
        SEC_YEL_GRN: begin r_d = q6_q; g_d = v6_q; b_d = p6_q; end
        SEC_GRN_CYN: begin r_d = p6_q; g_d = v6_q; b_d = t6_q; end
        SEC_CYN_BLU: begin r_d = p6_q; g_d = q6_q; b_d = v6_q; end
        SEC_BLU_MAG: begin r_d = t6_q; g_d = p6_q; b_d = v6_q; end
        default:     begin r_d = v6_q; g_d = p6_q; b_d = q6_q; end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      red_q   <= r_d[COLOR_W-1:0];
      green_q <= g_d[COLOR_W-1:0];
      blue_q  <= b_d[COLOR_W-1:0];
    end
  end

  assign m_axis_tdata = {5'd0, blue_q, green_q, red_q};

  `include "hsv_to_rgb_converter_assert.svh"

  `HSV_ASSERT(a_split_range, vld_q[1] |-> (y2_q < YW'(((960 << F) >> 6)) && sec2_q <= SEC_MAG_RED), "sector split out of range")
  `HSV_ASSERT(a_qtp_bound, vld_q[5] |-> (q6_q <= v6_q && t6_q <= v6_q && p6_q <= v6_q), "q t p exceed value")
  `HSV_ASSERT(a_gray_out, (vld_q[5] && zero6_q && en) |=> (red_q == green_q && green_q == blue_q), "gray pixel channels differ")
  `HSV_ASSERT(a_stall_hold, !en |=> $stable(vld_q), "pipeline moved while stalled")

endmodule

@@ verif/hsv_to_rgb_converter_tb.sv @@
module hsv_to_rgb_converter_tb;
  import hsv_pkg::*;

  localparam int FRAC        = 8;
  localparam int ONE         = 1 << FRAC;
  localparam int HUE_TURN    = 5760;
  localparam int HUE_SPAN    = 960;
  localparam int RAND_PIXELS = 400;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN       = 40;

  typedef struct packed {
    logic [8:0] red;
    logic [8:0] green;
    logic [8:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [15:0] hue;
    logic [10:0] sat;
    logic [10:0] bri;
    logic        typed;
    rgb_t        want;
  } hsv_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  rgb_t expected_pixels [$];
  int   error_count   = 0;
  int   checked_count = 0;
  int   cycle_count   = 0;
  int   stall_left    = 0;
  logic steady_phase  = 1'b0;

  // hue, saturation, brightness, typed, expected rgb
  hsv_row_t dir_rows [0:21] = '{
    '{16'sd0,     11'sd0,    11'sd128,  1'b1, '{9'd128, 9'd128, 9'd128}},
    '{16'sd0,     -11'sd5,   11'sd200,  1'b1, '{9'd200, 9'd200, 9'd200}},
    '{16'sd1000,  11'sd0,    11'sd1023, 1'b1, '{9'd256, 9'd256, 9'd256}},
    '{16'sd1000,  11'sd0,    11'h400,   1'b1, '{9'd0,   9'd0,   9'd0}},
    '{16'sd0,     11'sd256,  11'sd256,  1'b1, '{9'd256, 9'd0,   9'd0}},
    '{16'sd960,   11'sd256,  11'sd256,  1'b1, '{9'd256, 9'd256, 9'd0}},
    '{16'sd1920,  11'sd256,  11'sd256,  1'b1, '{9'd0,   9'd256, 9'd0}},
    '{16'sd2880,  11'sd256,  11'sd256,  1'b1, '{9'd0,   9'd256, 9'd256}},
    '{16'sd3840,  11'sd256,  11'sd256,  1'b1, '{9'd0,   9'd0,   9'd256}},
    '{16'sd4800,  11'sd256,  11'sd256,  1'b1, '{9'd256, 9'd0,   9'd256}},
    '{16'sd5760,  11'sd256,  11'sd256,  1'b1, '{9'd256, 9'd0,   9'd0}},
    '{-16'sd5760, 11'sd256,  11'sd256,  1'b1, '{9'd256, 9'd0,   9'd0}},
    '{16'sd4000,  11'sd255,  -11'sd1,   1'b1, '{9'd0,   9'd0,   9'd0}},
    '{-16'sd1,    11'sd1023, 11'sd256,  1'b0, '{9'd0,   9'd0,   9'd0}},
    '{16'sd32767, 11'sd200,  11'sd180,  1'b0, '{9'd0,   9'd0,   9'd0}},
    '{16'h8000,   11'sd128,  11'sd1023, 1'b0, '{9'd0,   9'd0,   9'd0}},
    '{16'sd5759,  11'sd100,  11'sd200,  1'b0, '{9'd0,   9'd0,   9'd0}},
    '{16'sd479,   11'sd256,  11'sd256,  1'b0, '{9'd0,   9'd0,   9'd0}},
    '{16'sd1440,  11'sd128,  11'sd256,  1'b0, '{9'd0,   9'd0,   9'd0}},
    '{16'sd2000,  11'sd1,    11'sd255,  1'b0, '{9'd0,   9'd0,   9'd0}},
    '{16'h5555,   11'h2AA,   11'h555,   1'b0, '{9'd0,   9'd0,   9'd0}},
    '{16'hAAAA,   11'h555,   11'h2AA,   1'b0, '{9'd0,   9'd0,   9'd0}}
  };

  hsv_to_rgb_converter #(
    .COLOR_FRAC_BITS(FRAC)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic int clamp_unit(input int x);
    if (x < 0) return 0;
    if (x > ONE) return ONE;
    return x;
  endfunction

  function automatic rgb_t convert_pixel(input logic [15:0] hue, input logic [10:0] sat,
                                         input logic [10:0] bri);
    int      h;
    int      s;
    int      v;
    int      rem;
    int      f;
    int      p;
    int      q;
    int      t;
    sector_e sect;
    rgb_t    px;
    h = int'($signed(hue)) % HUE_TURN;
    if (h < 0) h += HUE_TURN;
    s = clamp_unit(int'($signed(sat)));
    v = clamp_unit(int'($signed(bri)));
    if (s == 0) begin
      px = '{9'(v), 9'(v), 9'(v)};
    end else begin
      sect = sector_e'(3'(h / HUE_SPAN));
      rem  = h % HUE_SPAN;
      f    = (rem << FRAC) / HUE_SPAN;
      p    = (v * (ONE - s)) >> FRAC;
      q    = (v * (ONE - ((s * f) >> FRAC))) >> FRAC;
      t    = (v * (ONE - ((s * (ONE - f)) >> FRAC))) >> FRAC;
      case (sect)
        SEC_RED_YEL: px = '{9'(v), 9'(t), 9'(p)};
        SEC_YEL_GRN: px = '{9'(q), 9'(v), 9'(p)};
        SEC_GRN_CYN: px = '{9'(p), 9'(v), 9'(t)};
        SEC_CYN_BLU: px = '{9'(p), 9'(q), 9'(v)};
        SEC_BLU_MAG: px = '{9'(t), 9'(p), 9'(v)};
        default:     px = '{9'(v), 9'(p), 9'(q)};
      endcase
    end
    return px;
  endfunction

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (steady_phase || r < 55) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  task automatic send_pixel(input logic [15:0] hue, input logic [10:0] sat,
                            input logic [10:0] bri, input rgb_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, bri, sat, hue};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_pixels.push_back(want);
  endtask

  task automatic check_channel(input string name, input logic [8:0] want,
                               input logic [8:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    = stall_left - 1;
    end else if (steady_phase || $urandom_range(0, 99) < 60) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b0;
      stall_left = ($urandom_range(0, 9) < 8) ? int'($urandom_range(0, 2))
                                              : int'($urandom_range(7, 39));
    end
  end

  always @(posedge clk_i) begin
    rgb_t got;
    rgb_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[8:0], m_axis_tdata[17:9], m_axis_tdata[26:18]};
      if (expected_pixels.size() == 0) begin
        $error("output beat with no pixel pending: %0d %0d %0d",
               got.red, got.green, got.blue);
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        checked_count++;
        check_channel("red", want.red, got.red);
        check_channel("green", want.green, got.green);
        check_channel("blue", want.blue, got.blue);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d pixels pending", cycle_count,
             expected_pixels.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [15:0] hue;
    logic [10:0] sat;
    logic [10:0] bri;
    rgb_t        want;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      want = dir_rows[i].typed ? dir_rows[i].want
                               : convert_pixel(dir_rows[i].hue, dir_rows[i].sat, dir_rows[i].bri);
      send_pixel(dir_rows[i].hue, dir_rows[i].sat, dir_rows[i].bri, want);
    end

    for (int n = 0; n < RAND_PIXELS; n++) begin
      steady_phase <= ((n / 50) % 3 == 2);
      if ($urandom_range(0, 4) == 0) begin
        hue = 16'($urandom);
        sat = 11'($urandom);
        bri = 11'($urandom);
      end else begin
        hue = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5759));
        case ($urandom_range(0, 9))
          0:       sat = 11'd0;
          1:       sat = 11'd256;
          2:       sat = 11'($urandom);
          default: sat = 11'($urandom_range(1, 256));
        endcase
        case ($urandom_range(0, 9))
          0:       bri = 11'($urandom);
          1:       bri = 11'd256;
          default: bri = 11'($urandom_range(0, 256));
        endcase
      end
      send_pixel(hue, sat, bri, convert_pixel(hue, sat, bri));
    end
    s_axis_tvalid <= 1'b0;

    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("%0d pixels sent (%0d directed, %0d random), %0d output beats compared",
             $size(dir_rows) + RAND_PIXELS, $size(dir_rows), RAND_PIXELS, checked_count);
    $display("covered hue wrap, clamping, gray and all six sectors with source gaps and sink stalls");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
